// File: hw/rtl/ieu_pkg.sv
package ieu_pkg;

    localparam int XLEN = 32;
    localparam int RIDX = 5;

    typedef enum logic [5:0] {
        OP_ADD = 6'd0, OP_ADDU = 6'd1, OP_SUB = 6'd2, OP_SUBU = 6'd3,
        OP_AND = 6'd4, OP_OR = 6'd5, OP_XOR = 6'd6, OP_NOR = 6'd7,
        OP_SLT = 6'd8, OP_SLTU = 6'd9, OP_SLL = 6'd10, OP_SRL = 6'd11,
        OP_SRA = 6'd12, OP_SLLV = 6'd13, OP_SRLV = 6'd14, OP_SRAV = 6'd15,
        OP_MULT = 6'd16, OP_MULTU = 6'd17, OP_DIV = 6'd18, OP_DIVU = 6'd19,
        OP_MFHI = 6'd20, OP_MFLO = 6'd21, OP_MTHI = 6'd22, OP_MTLO = 6'd23,
        OP_ADDI = 6'd24, OP_ADDIU = 6'd25, OP_SLTI = 6'd26, OP_SLTIU = 6'd27,
        OP_ANDI = 6'd28, OP_ORI = 6'd29, OP_XORI = 6'd30, OP_LUI = 6'd31,
        OP_BEQ = 6'd32, OP_BNE = 6'd33, OP_BLEZ = 6'd34, OP_BGTZ = 6'd35,
        OP_BLTZ = 6'd36, OP_BGEZ = 6'd37, OP_BLTZAL = 6'd38, OP_BGEZAL = 6'd39,
        OP_JAL = 6'd40, OP_HRD = 6'd41, OP_HWR = 6'd42
    } t_op;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_OVF = 2'd1;
    localparam logic [1:0] ST_LINK31 = 2'd2;

    localparam logic [XLEN-1:0] LINK_OFFSET = 32'd8;
    localparam logic [RIDX-1:0] LINK_REG = 5'd31;
    localparam int MD_STEPS = 32;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request, read registers
        logic exec;      // non-iterative op: compute and commit
        logic md_start;  // init multiply/divide iteration
        logic md_step;   // one iteration
        logic md_done;   // commit hi/lo
        logic out_load;  // load output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_md;
        logic md_last;
    } t_stat;

endpackage

// File: hw/rtl/ieu_ctrl.sv
module ieu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  ieu_pkg::t_stat i_stat,
    output ieu_pkg::t_cmd  o_cmd
);
    import ieu_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DEC  = 5'b00010,
        S_MD   = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   out_free;

    assign out_free = !r_ovalid || !i_stall;
    assign o_valid  = r_ovalid;
    assign o_stall  = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && i_stall;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_stat.is_md) begin
                    o_cmd.md_start = 1'b1;
                    n_state = S_MD;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_MD: begin
                o_cmd.md_step = 1'b1;
                if (i_stat.md_last) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.md_done = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

// File: hw/rtl/ieu_dp.sv
module ieu_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ieu_pkg::t_cmd              i_cmd,
    output ieu_pkg::t_stat             o_stat,
    input  logic [5:0]                 i_op,
    input  logic [ieu_pkg::RIDX-1:0]   i_rs,
    input  logic [ieu_pkg::RIDX-1:0]   i_rt,
    input  logic [ieu_pkg::RIDX-1:0]   i_rd,
    input  logic [4:0]                 i_sa,
    input  logic signed [15:0]         i_imm,
    input  logic [ieu_pkg::XLEN-1:0]   i_pc,
    input  logic [ieu_pkg::XLEN-1:0]   i_wv,
    output logic [ieu_pkg::XLEN-1:0]   o_value,
    output logic [ieu_pkg::RIDX-1:0]   o_dest,
    output logic                       o_written,
    output logic                       o_taken,
    output logic [1:0]                 o_status
);
    import ieu_pkg::*;

    logic [XLEN-1:0] r_gpr [1:31];
    logic [XLEN-1:0] r_hi, r_lo;

    logic [5:0]      r_op;
    logic [RIDX-1:0] r_rs, r_rt, r_rd;
    logic [4:0]      r_sa;
    logic [15:0]     r_imm;
    logic [XLEN-1:0] r_pc, r_wv, r_a, r_b, r_h;

    // multiply/divide iteration state
    logic [XLEN-1:0] r_acc, r_q, r_m;
    logic [5:0]      r_cnt;
    logic            r_neg_q, r_neg_r, r_md_ok, r_is_mul;

    // result before the output register
    logic [XLEN-1:0] r_val;
    logic [RIDX-1:0] r_tgt;
    logic            r_wr, r_tk;
    logic [1:0]      r_st;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_rs  <= i_rs;
            r_rt  <= i_rt;
            r_rd  <= i_rd;
            r_sa  <= i_sa;
            r_imm <= i_imm;
            r_pc  <= i_pc;
            r_wv  <= i_wv;
            r_a   <= (i_rs == '0) ? '0 : r_gpr[i_rs];
            r_b   <= (i_rt == '0) ? '0 : r_gpr[i_rt];
            r_h   <= (i_rd == '0) ? '0 : r_gpr[i_rd];
        end
    end

    logic [XLEN-1:0] simm, zimm, sum, dif, sumi;
    assign simm = {{16{r_imm[15]}}, r_imm};
    assign zimm = {16'd0, r_imm};
    assign sum  = r_a + r_b;
    assign dif  = r_a - r_b;
    assign sumi = r_a + simm;

    logic [XLEN-1:0] c_val;
    logic [RIDX-1:0] c_tgt;
    logic            c_wr, c_tk, c_hiwr, c_lowr;
    logic [1:0]      c_st;
    logic            a_neg;
    assign a_neg = r_a[XLEN-1];

    always_comb begin
        c_val = '0; c_tgt = '0; c_wr = 1'b0; c_tk = 1'b0; c_st = ST_OK;
        c_hiwr = 1'b0; c_lowr = 1'b0;
        case (r_op)
            OP_ADD: begin
                c_tgt = r_rd; c_wr = 1'b1;
                if (((r_a ^ sum) & (r_b ^ sum)) >> (XLEN-1) != '0) c_st = ST_OVF;
                else c_val = sum;
            end
            OP_ADDU: begin c_val = sum; c_tgt = r_rd; c_wr = 1'b1; end
            OP_SUB: begin
                c_tgt = r_rd; c_wr = 1'b1;
                if (((r_a ^ r_b) & (r_a ^ dif)) >> (XLEN-1) != '0) c_st = ST_OVF;
                else c_val = dif;
            end
            OP_SUBU: begin c_val = dif; c_tgt = r_rd; c_wr = 1'b1; end
            OP_AND: begin c_val = r_a & r_b; c_tgt = r_rd; c_wr = 1'b1; end
            OP_OR:  begin c_val = r_a | r_b; c_tgt = r_rd; c_wr = 1'b1; end
            OP_XOR: begin c_val = r_a ^ r_b; c_tgt = r_rd; c_wr = 1'b1; end
            OP_NOR: begin c_val = ~(r_a | r_b); c_tgt = r_rd; c_wr = 1'b1; end
            OP_SLT: begin
                c_val = {31'd0, $signed(r_a) < $signed(r_b)}; c_tgt = r_rd; c_wr = 1'b1;
            end
            OP_SLTU: begin c_val = {31'd0, r_a < r_b}; c_tgt = r_rd; c_wr = 1'b1; end
            OP_SLL: begin c_val = r_b << r_sa; c_tgt = r_rd; c_wr = 1'b1; end
            OP_SRL: begin c_val = r_b >> r_sa; c_tgt = r_rd; c_wr = 1'b1; end
            OP_SRA: begin
                c_val = XLEN'($signed(r_b) >>> r_sa); c_tgt = r_rd; c_wr = 1'b1;
            end
            OP_SLLV: begin c_val = r_b << r_a[4:0]; c_tgt = r_rd; c_wr = 1'b1; end
            OP_SRLV: begin c_val = r_b >> r_a[4:0]; c_tgt = r_rd; c_wr = 1'b1; end
            OP_SRAV: begin
                c_val = XLEN'($signed(r_b) >>> r_a[4:0]); c_tgt = r_rd; c_wr = 1'b1;
            end
            OP_MFHI: begin c_val = r_hi; c_tgt = r_rd; c_wr = 1'b1; end
            OP_MFLO: begin c_val = r_lo; c_tgt = r_rd; c_wr = 1'b1; end
            OP_MTHI: c_hiwr = 1'b1;
            OP_MTLO: c_lowr = 1'b1;
            OP_ADDI: begin
                c_tgt = r_rt; c_wr = 1'b1;
                if (((r_a ^ sumi) & (simm ^ sumi)) >> (XLEN-1) != '0) c_st = ST_OVF;
                else c_val = sumi;
            end
            OP_ADDIU: begin c_val = sumi; c_tgt = r_rt; c_wr = 1'b1; end
            OP_SLTI: begin
                c_val = {31'd0, $signed(r_a) < $signed(simm)}; c_tgt = r_rt; c_wr = 1'b1;
            end
            OP_SLTIU: begin c_val = {31'd0, r_a < simm}; c_tgt = r_rt; c_wr = 1'b1; end
            OP_ANDI: begin c_val = r_a & zimm; c_tgt = r_rt; c_wr = 1'b1; end
            OP_ORI:  begin c_val = r_a | zimm; c_tgt = r_rt; c_wr = 1'b1; end
            OP_XORI: begin c_val = r_a ^ zimm; c_tgt = r_rt; c_wr = 1'b1; end
            OP_LUI:  begin c_val = {r_imm, 16'd0}; c_tgt = r_rt; c_wr = 1'b1; end
            OP_BEQ:  c_tk = (r_a == r_b);
            OP_BNE:  c_tk = (r_a != r_b);
            OP_BLEZ: c_tk = a_neg || (r_a == '0);
            OP_BGTZ: c_tk = !a_neg && (r_a != '0);
            OP_BLTZ: c_tk = a_neg;
            OP_BGEZ: c_tk = !a_neg;
            OP_BLTZAL, OP_BGEZAL: begin
                c_tgt = LINK_REG;
                if (r_rs == LINK_REG) c_st = ST_LINK31;
                else begin
                    c_tk  = (r_op == OP_BLTZAL) ? a_neg : !a_neg;
                    c_val = r_pc + LINK_OFFSET;
                    c_wr  = 1'b1;
                end
            end
            OP_JAL: begin c_val = r_pc + LINK_OFFSET; c_tgt = LINK_REG; c_wr = 1'b1; end
            OP_HRD: begin c_val = r_h; c_tgt = r_rd; end
            OP_HWR: begin c_val = r_wv; c_tgt = r_rd; c_wr = 1'b1; end
            default: ;
        endcase
        if (c_st != ST_OK || c_tgt == '0) c_wr = 1'b0;
    end

    assign o_stat.is_md   = (r_op == OP_MULT) || (r_op == OP_MULTU) ||
                            (r_op == OP_DIV) || (r_op == OP_DIVU);
    assign o_stat.md_last = (r_cnt == 6'(MD_STEPS - 1));

    // shift-add multiply / restoring divide on magnitudes, one bit a cycle
    logic            sgn, mul_op;
    logic [XLEN-1:0] ma, mb;
    logic [XLEN:0]   madd, trial;
    logic [2*XLEN-1:0] prod, prod_n;
    logic [XLEN-1:0] q_n, r_n;

    assign mul_op = (r_op == OP_MULT) || (r_op == OP_MULTU);
    assign sgn    = (r_op == OP_MULT) || (r_op == OP_DIV);
    assign ma     = (sgn && a_neg) ? (~r_a + 1'b1) : r_a;
    assign mb     = (sgn && r_b[XLEN-1]) ? (~r_b + 1'b1) : r_b;
    assign madd   = {1'b0, r_acc} + {1'b0, (r_q[0] ? r_m : '0)};
    assign trial  = {r_acc, r_q[XLEN-1]} - {1'b0, r_m};
    assign prod   = {r_acc, r_q};
    assign prod_n = r_neg_q ? (~prod + 1'b1) : prod;
    assign q_n    = r_neg_q ? (~r_q + 1'b1) : r_q;
    assign r_n    = r_neg_r ? (~r_acc + 1'b1) : r_acc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.md_start) begin
            r_acc    <= '0;
            r_q      <= ma;
            r_m      <= mb;
            r_cnt    <= '0;
            r_is_mul <= mul_op;
            r_neg_q  <= sgn && (a_neg ^ r_b[XLEN-1]);
            r_neg_r  <= sgn && a_neg && !mul_op;
            r_md_ok  <= mul_op || ((r_b != '0) &&
                        !(sgn && r_a == {1'b1, {(XLEN-1){1'b0}}} && r_b == '1));
        end else if (i_cmd.md_step) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_is_mul) begin
                r_acc <= madd[XLEN:1];
                r_q   <= {madd[0], r_q[XLEN-1:1]};
            end else if (!trial[XLEN]) begin
                r_acc <= trial[XLEN-1:0];
                r_q   <= {r_q[XLEN-2:0], 1'b1};
            end else begin
                r_acc <= {r_acc[XLEN-2:0], r_q[XLEN-1]};
                r_q   <= {r_q[XLEN-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi <= '0;
            r_lo <= '0;
        end else if (i_cmd.exec) begin
            if (c_hiwr) r_hi <= r_a;
            if (c_lowr) r_lo <= r_a;
        end else if (i_cmd.md_done && r_md_ok) begin
            if (r_is_mul) begin
                r_hi <= prod_n[2*XLEN-1:XLEN];
                r_lo <= prod_n[XLEN-1:0];
            end else begin
                r_hi <= r_n;
                r_lo <= q_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k < 32; k++) r_gpr[k] <= '0;
        end else if (i_cmd.exec && c_wr) begin
            r_gpr[c_tgt] <= c_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_val <= c_val; r_tgt <= c_tgt; r_wr <= c_wr; r_tk <= c_tk; r_st <= c_st;
        end else if (i_cmd.md_start) begin
            r_val <= '0; r_tgt <= '0; r_wr <= 1'b0; r_tk <= 1'b0; r_st <= ST_OK;
        end
        if (i_cmd.out_load) begin
            o_value   <= r_val;
            o_dest    <= r_tgt;
            o_written <= r_wr;
            o_taken   <= r_tk;
            o_status  <= r_st;
        end
    end

endmodule

// File: hw/rtl/integer_execute_unit_with_regfile.sv
// each request is registered, executed, then loaded into the output register;
// o_stall is high until that load (held by output stall), so no requests overlap;
// mult and div iterate one bit per cycle over 32 steps in a shared shift unit
// reset (synchronous, active low) clears r1..r31, hi, lo and the handshake state
module integer_execute_unit_with_regfile (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [5:0]   i_cmd,
    input  logic [4:0]   i_src_a_index,
    input  logic [4:0]   i_src_b_index,
    input  logic [4:0]   i_dest_index,
    input  logic [4:0]   i_shift_amount,
    input  logic signed [15:0] i_immediate,
    input  logic [31:0]  i_pc_value,
    input  logic [31:0]  i_write_value,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [31:0]  o_result_value,
    output logic [4:0]   o_dest_register,
    output logic         o_register_written,
    output logic         o_branch_taken,
    output logic [1:0]   o_status
);
    import ieu_pkg::*;

    // control bundle from the sequencer, decode status back
    t_cmd  cmd;
    t_stat stat;

    // sequencer: idle -> decode -> (iterate -> finish) -> output
    ieu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // register file, alu, hi/lo and the multiply/divide unit
    ieu_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_op      (i_cmd),
        .i_rs      (i_src_a_index),
        .i_rt      (i_src_b_index),
        .i_rd      (i_dest_index),
        .i_sa      (i_shift_amount),
        .i_imm     (i_immediate),
        .i_pc      (i_pc_value),
        .i_wv      (i_write_value),
        .o_value   (o_result_value),
        .o_dest    (o_dest_register),
        .o_written (o_register_written),
        .o_taken   (o_branch_taken),
        .o_status  (o_status)
    );

endmodule

// File: hw/rtl/ieu_checker.sv
module ieu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_result_value,
    input logic [4:0]  o_dest_register,
    input logic        o_register_written,
    input logic [1:0]  o_status
);
    import ieu_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_value))
        else $error("result changed while stalled");

    a_no_r0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_register_written && o_dest_register == '0))
        else $error("write reported to r0");

    a_trap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> !o_register_written)
        else $error("write despite trap");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("accepted twice in a row");

endmodule

bind integer_execute_unit_with_regfile ieu_checker u_ieu_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import ieu_pkg::*;

    // one decoded instruction as driven on the request channel
    typedef struct {
        logic [5:0]  cmd;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sa;
        logic [15:0] imm;
        logic [31:0] pc;
        logic [31:0] wv;
    } t_instr;

    // architectural outcome of one instruction
    typedef struct {
        logic [31:0] value;
        logic [4:0]  dest;
        logic        wr;
        logic        taken;
        logic [1:0]  st;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [5:0]  i_cmd;
    logic [4:0]  i_src_a_index;
    logic [4:0]  i_src_b_index;
    logic [4:0]  i_dest_index;
    logic [4:0]  i_shift_amount;
    logic signed [15:0] i_immediate;
    logic [31:0] i_pc_value;
    logic [31:0] i_write_value;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_result_value;
    logic [4:0]  o_dest_register;
    logic        o_register_written;
    logic        o_branch_taken;
    logic [1:0]  o_status;

    integer_execute_unit_with_regfile dut (.*);

    t_instr   pending_q[$];
    t_outcome outcome_q[$];

    // shadow architectural state
    logic [31:0] shadow_gpr[32];
    logic [31:0] shadow_hi;
    logic [31:0] shadow_lo;

    int  n_sent;
    int  n_checked;
    int  n_errors;
    int  n_traps;
    int  n_taken;
    int  tx_gap;
    int  rx_gap;
    bit  hold_tx;
    bit  stim_done;
    int  op_seen[64];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [31:0] gpr_read(logic [4:0] idx);
        return (idx == 5'd0) ? 32'd0 : shadow_gpr[idx];
    endfunction

    // executes one instruction on the shadow state, returns what the unit must report
    function automatic t_outcome execute_instr(t_instr ins);
        t_outcome    res;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] simm;
        logic [31:0] zimm;
        logic [31:0] sum;
        logic [63:0] prod;
        bit          wr;
        a    = gpr_read(ins.rs);
        b    = gpr_read(ins.rt);
        simm = {{16{ins.imm[15]}}, ins.imm};
        zimm = {16'd0, ins.imm};
        res  = '{value: 32'd0, dest: 5'd0, wr: 1'b0, taken: 1'b0, st: ST_OK};
        wr   = 1'b0;
        case (ins.cmd)
            OP_ADD, OP_SUB, OP_ADDI: begin
                // signed overflow traps: value dropped, no write
                if (ins.cmd == OP_ADD) begin
                    sum = a + b;
                    res.dest = ins.rd;
                end else if (ins.cmd == OP_SUB) begin
                    sum = a - b;
                    res.dest = ins.rd;
                end else begin
                    sum = a + simm;
                    res.dest = ins.rt;
                end
                wr = 1'b1;
                if ((ins.cmd == OP_ADD && ((a ^ sum) & (b ^ sum) & 32'h8000_0000) != 0) ||
                    (ins.cmd == OP_SUB && ((a ^ b) & (a ^ sum) & 32'h8000_0000) != 0) ||
                    (ins.cmd == OP_ADDI && ((a ^ sum) & (simm ^ sum) & 32'h8000_0000) != 0))
                    res.st = ST_OVF;
                else
                    res.value = sum;
            end
            OP_ADDU:  begin res.value = a + b; res.dest = ins.rd; wr = 1'b1; end
            OP_SUBU:  begin res.value = a - b; res.dest = ins.rd; wr = 1'b1; end
            OP_AND:   begin res.value = a & b; res.dest = ins.rd; wr = 1'b1; end
            OP_OR:    begin res.value = a | b; res.dest = ins.rd; wr = 1'b1; end
            OP_XOR:   begin res.value = a ^ b; res.dest = ins.rd; wr = 1'b1; end
            OP_NOR:   begin res.value = ~(a | b); res.dest = ins.rd; wr = 1'b1; end
            OP_SLT: begin
                res.value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                res.dest = ins.rd; wr = 1'b1;
            end
            OP_SLTU: begin
                res.value = (a < b) ? 32'd1 : 32'd0;
                res.dest = ins.rd; wr = 1'b1;
            end
            OP_SLL:   begin res.value = b << ins.sa; res.dest = ins.rd; wr = 1'b1; end
            OP_SRL:   begin res.value = b >> ins.sa; res.dest = ins.rd; wr = 1'b1; end
            OP_SRA: begin
                res.value = $signed(b) >>> ins.sa;
                res.dest = ins.rd; wr = 1'b1;
            end
            OP_SLLV:  begin res.value = b << a[4:0]; res.dest = ins.rd; wr = 1'b1; end
            OP_SRLV:  begin res.value = b >> a[4:0]; res.dest = ins.rd; wr = 1'b1; end
            OP_SRAV: begin
                res.value = $signed(b) >>> a[4:0];
                res.dest = ins.rd; wr = 1'b1;
            end
            OP_MULT: begin
                prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                {shadow_hi, shadow_lo} = prod;
            end
            OP_MULTU: begin
                prod = {32'd0, a} * {32'd0, b};
                {shadow_hi, shadow_lo} = prod;
            end
            OP_DIV: begin
                // hi/lo keep their values on zero divisor and the one overflowing quotient
                if (b != 0 && !(a == 32'h8000_0000 && b == 32'hFFFF_FFFF)) begin
                    shadow_lo = $signed(a) / $signed(b);
                    shadow_hi = $signed(a) % $signed(b);
                end
            end
            OP_DIVU: begin
                if (b != 0) begin
                    shadow_lo = a / b;
                    shadow_hi = a % b;
                end
            end
            OP_MFHI:  begin res.value = shadow_hi; res.dest = ins.rd; wr = 1'b1; end
            OP_MFLO:  begin res.value = shadow_lo; res.dest = ins.rd; wr = 1'b1; end
            OP_MTHI:  shadow_hi = a;
            OP_MTLO:  shadow_lo = a;
            OP_ADDIU: begin res.value = a + simm; res.dest = ins.rt; wr = 1'b1; end
            OP_SLTI: begin
                res.value = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
                res.dest = ins.rt; wr = 1'b1;
            end
            OP_SLTIU: begin
                res.value = (a < simm) ? 32'd1 : 32'd0;
                res.dest = ins.rt; wr = 1'b1;
            end
            OP_ANDI:  begin res.value = a & zimm; res.dest = ins.rt; wr = 1'b1; end
            OP_ORI:   begin res.value = a | zimm; res.dest = ins.rt; wr = 1'b1; end
            OP_XORI:  begin res.value = a ^ zimm; res.dest = ins.rt; wr = 1'b1; end
            OP_LUI:   begin res.value = {ins.imm, 16'd0}; res.dest = ins.rt; wr = 1'b1; end
            OP_BEQ:   res.taken = (a == b);
            OP_BNE:   res.taken = (a != b);
            OP_BLEZ:  res.taken = ($signed(a) <= 0);
            OP_BGTZ:  res.taken = ($signed(a) > 0);
            OP_BLTZ:  res.taken = a[31];
            OP_BGEZ:  res.taken = !a[31];
            OP_BLTZAL, OP_BGEZAL: begin
                res.dest = LINK_REG;
                if (ins.rs == LINK_REG) begin
                    // linking through the source register is refused
                    res.st = ST_LINK31;
                end else begin
                    res.taken = (ins.cmd == OP_BLTZAL) ? a[31] : !a[31];
                    res.value = ins.pc + LINK_OFFSET;
                    wr = 1'b1;
                end
            end
            OP_JAL: begin
                res.value = ins.pc + LINK_OFFSET;
                res.dest = LINK_REG; wr = 1'b1;
            end
            OP_HRD:   begin res.value = gpr_read(ins.rd); res.dest = ins.rd; end
            OP_HWR:   begin res.value = ins.wv; res.dest = ins.rd; wr = 1'b1; end
            default: ;
        endcase
        if (wr && res.st == ST_OK && res.dest != 5'd0) begin
            shadow_gpr[res.dest] = res.value;
            res.wr = 1'b1;
        end
        return res;
    endfunction

    // operands from a small pool of corner values, small values or fully random
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return 32'd0;
            4: return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_instr make_instr(logic [5:0] cmd, logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [15:0] imm, logic [31:0] wv);
        t_instr ins;
        ins.cmd = cmd;
        ins.rs  = rs;
        ins.rt  = rt;
        ins.rd  = rd;
        ins.sa  = $urandom_range(0, 31);
        ins.imm = imm;
        ins.pc  = $urandom;
        ins.wv  = wv;
        return ins;
    endfunction

    function automatic t_instr random_instr();
        t_instr ins;
        int     pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            // seed registers through host writes so arithmetic sees corner operands
            ins = make_instr(OP_HWR, 5'd0, 5'd0, $urandom_range(0, 31), 16'd0, rand_word());
        end else if (pick < 97) begin
            ins = make_instr($urandom_range(0, 42), $urandom_range(0, 31),
                             $urandom_range(0, 31), $urandom_range(0, 31),
                             $urandom, $urandom);
            if ($urandom_range(0, 3) == 0)
                ins.imm = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            if ($urandom_range(0, 5) == 0)
                ins.pc = 32'hFFFF_FFF8 + $urandom_range(0, 7);
        end else begin
            // unused opcodes
            ins = make_instr($urandom_range(43, 63), $urandom, $urandom, $urandom,
                             $urandom, $urandom);
        end
        return ins;
    endfunction

    // stimulus
    initial begin
        t_instr ins;
        n_sent    = 0;
        stim_done = 1'b0;
        hold_tx   = 1'b0;
        for (int i = 0; i < 32; i++) shadow_gpr[i] = 32'd0;
        shadow_hi = 32'd0;
        shadow_lo = 32'd0;
        foreach (op_seen[i]) op_seen[i] = 0;

        // directed: corner values into registers, corner cases, then each operation once
        pending_q.push_back(make_instr(OP_HWR, 0, 0, 1, 0, 32'h7FFF_FFFF));
        pending_q.push_back(make_instr(OP_HWR, 0, 0, 2, 0, 32'h8000_0000));
        pending_q.push_back(make_instr(OP_HWR, 0, 0, 3, 0, 32'hFFFF_FFFF));
        pending_q.push_back(make_instr(OP_HWR, 0, 0, 0, 0, 32'h1234_5678));  // write to r0
        pending_q.push_back(make_instr(OP_HRD, 0, 0, 0, 0, 0));
        pending_q.push_back(make_instr(OP_ADD, 1, 1, 4, 0, 0));               // overflow trap
        pending_q.push_back(make_instr(OP_SUB, 2, 1, 4, 0, 0));               // overflow trap
        pending_q.push_back(make_instr(OP_ADDI, 1, 5, 0, 16'h7FFF, 0));       // overflow trap
        pending_q.push_back(make_instr(OP_DIV, 2, 3, 0, 0, 0));               // most negative / -1
        pending_q.push_back(make_instr(OP_DIVU, 1, 0, 0, 0, 0));              // divide by zero
        pending_q.push_back(make_instr(OP_MFHI, 0, 0, 6, 0, 0));
        pending_q.push_back(make_instr(OP_MFLO, 0, 0, 7, 0, 0));
        ins = make_instr(OP_SRA, 0, 2, 8, 0, 0);
        ins.sa = 5'd0;                                                  // arithmetic by zero
        pending_q.push_back(ins);
        pending_q.push_back(make_instr(OP_LUI, 0, 0, 0, 16'hFFFF, 0));        // lui to r0
        pending_q.push_back(make_instr(OP_BLTZAL, 31, 0, 0, 0, 0));           // link via r31
        pending_q.push_back(make_instr(OP_BGEZAL, 2, 0, 0, 0, 0));
        ins = make_instr(OP_JAL, 0, 0, 0, 0, 0);
        ins.pc = 32'hFFFF_FFFC;                                         // link wraps
        pending_q.push_back(ins);
        pending_q.push_back(make_instr(OP_MULT, 2, 2, 0, 0, 0));
        pending_q.push_back(make_instr(OP_MULTU, 3, 3, 0, 0, 0));
        pending_q.push_back(make_instr(OP_SLTIU, 1, 9, 0, 16'h8000, 0));
        pending_q.push_back(make_instr(6'd63, 1, 2, 3, 16'hFFFF, 32'hFFFF_FFFF));
        for (int op = 0; op <= 42; op++)
            pending_q.push_back(make_instr(op, $urandom, $urandom, $urandom, $urandom, $urandom));

        for (int i = 0; i < 2000; i++) begin
            pending_q.push_back(random_instr());
            // keep the driver only a few items ahead
            while (pending_q.size() > 8) @(posedge i_clk);
            if (i == 1000) begin
                // drain pause: sender holds off until every result is back
                while (pending_q.size() != 0) @(posedge i_clk);
                hold_tx = 1'b1;
                @(posedge i_clk);
                while (i_valid || outcome_q.size() != 0) @(posedge i_clk);
                hold_tx = 1'b0;
            end
        end
        stim_done = 1'b1;
    end

    // driver
    always @(posedge i_clk) begin
        t_instr ins;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap  <= 0;
        end else if (i_valid && !o_stall) begin
            // request accepted this edge: predict it, then decide what comes next
            ins.cmd = i_cmd; ins.rs = i_src_a_index; ins.rt = i_src_b_index;
            ins.rd = i_dest_index; ins.sa = i_shift_amount; ins.imm = i_immediate;
            ins.pc = i_pc_value; ins.wv = i_write_value;
            outcome_q.push_back(execute_instr(ins));
            if (ins.cmd[5:0] == OP_ADD || ins.cmd == OP_SUB || ins.cmd == OP_ADDI) n_traps++;
            op_seen[ins.cmd]++;
            n_sent++;
            i_valid <= 1'b0;
            tx_gap  <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : 0;
        end else if (!i_valid) begin
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
            end else if (pending_q.size() != 0 && !hold_tx) begin
                ins = pending_q.pop_front();
                i_valid        <= 1'b1;
                i_cmd          <= ins.cmd;
                i_src_a_index  <= ins.rs;
                i_src_b_index  <= ins.rt;
                i_dest_index   <= ins.rd;
                i_shift_amount <= ins.sa;
                i_immediate    <= ins.imm;
                i_pc_value     <= ins.pc;
                i_write_value  <= ins.wv;
            end
        end
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        t_outcome exp_out;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_gap  <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (outcome_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected result: value %h dest %0d", o_result_value,
                                 o_dest_register);
                end else begin
                    exp_out = outcome_q.pop_front();
                    n_checked++;
                    if (o_branch_taken) n_taken++;
                    if (o_result_value !== exp_out.value || o_dest_register !== exp_out.dest ||
                        o_register_written !== exp_out.wr || o_branch_taken !== exp_out.taken ||
                        o_status !== exp_out.st) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display({"mismatch #%0d: exp val %h rd %0d wr %b br %b st %0d,",
                                      " got val %h rd %0d wr %b br %b st %0d"},
                                     n_checked, exp_out.value, exp_out.dest, exp_out.wr,
                                     exp_out.taken, exp_out.st, o_result_value,
                                     o_dest_register, o_register_written, o_branch_taken,
                                     o_status);
                    end
                end
            end
            // stall pattern: runs of free flow mixed with random back-pressure
            if (rx_gap > 0) begin
                i_stall <= 1'b1;
                rx_gap  <= rx_gap - 1;
            end else begin
                i_stall <= 1'b0;
                rx_gap  <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
            end
        end
    end

    // reset, then wait for drain and report
    initial begin
        int ops_hit;
        n_checked = 0;
        n_errors  = 0;
        n_traps   = 0;
        n_taken   = 0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_stall        = 1'b0;
        i_cmd          = '0;
        i_src_a_index  = '0;
        i_src_b_index  = '0;
        i_dest_index   = '0;
        i_shift_amount = '0;
        i_immediate    = '0;
        i_pc_value     = '0;
        i_write_value  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && pending_q.size() == 0);
        @(posedge i_clk);
        while (i_valid || outcome_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        ops_hit = 0;
        for (int i = 0; i <= 42; i++) if (op_seen[i] != 0) ops_hit++;
        $display("covered %0d requests, %0d results checked, %0d of 43 operations used",
                 n_sent, n_checked, ops_hit);
        $display("branches taken %0d, add/sub/addi requests %0d, mismatches %0d",
                 n_taken, n_traps, n_errors);
        if (n_errors == 0 && outcome_q.size() == 0)
            $display("** integer_execute_unit_with_regfile: PASSED **");
        else
            $display("** integer_execute_unit_with_regfile: FAILED **");
        $finish;
    end

    // watchdog: roughly 2100 requests at their worst, several times over
    initial begin
        #(20ns * 1500000);
        $display("timeout waiting for results");
        $display("** integer_execute_unit_with_regfile: FAILED **");
        $finish;
    end

endmodule
